### rtl/assert_macros.svh
// assertion helpers shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define SBS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sbs assertion failed");

// consequent must hold a fixed number of cycles after the antecedent
`define SBS_ASSERT_LATER(label, clk, rst_n, ante, n, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
		else $error("sbs assertion failed");

// expression must hold at every edge out of reset
`define SBS_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("sbs assertion failed");

`endif

### rtl/sbs_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbs_pkg
// widths and lane/product records for the segment/box slab test
// ---------------------------------------------------------------------------
package sbs_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int DIFF_W = COORD_WIDTH + 1;   // coordinate difference
	localparam int NUM_W  = COORD_WIDTH + 2;   // difference after sign flip
	localparam int PROD_W = 2 * NUM_W;         // cross product
	localparam int NUM_AXES = 3;
	localparam int LATENCY  = 4;

	// one axis after normalisation: slab parameters are n0/dm and n1/dm
	typedef struct packed {
		logic                     par;     // segment does not move on this axis
		logic                     par_ok;  // start lies inside the slab
		logic signed [NUM_W-1:0]  n0;      // entry numerator
		logic signed [NUM_W-1:0]  n1;      // exit numerator
		logic [DIFF_W-1:0]        dm;      // denominator, never negative; zero on a parallel axis
	} lane_t;

	// one axis after the cross multiplications
	typedef struct packed {
		logic                     par;
		logic                     ok;      // slab test against [0,1] or parallel test
		logic signed [PROD_W-1:0] p0_a;    // n0 * dm of next axis
		logic signed [PROD_W-1:0] p0_b;    // n0 * dm of axis after next
		logic signed [PROD_W-1:0] p1_a;    // n1 * dm of next axis
		logic signed [PROD_W-1:0] p1_b;    // n1 * dm of axis after next
	} prod_t;

endpackage

### rtl/sbs_axis_lane.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbs_axis_lane
// per-axis differences, direction flip and sort of the slab parameters
// ---------------------------------------------------------------------------
module sbs_axis_lane (
	input  logic                                     clk,
	input  logic signed [sbs_pkg::COORD_WIDTH-1:0]   s,
	input  logic signed [sbs_pkg::COORD_WIDTH-1:0]   e,
	input  logic signed [sbs_pkg::COORD_WIDTH-1:0]   lo,
	input  logic signed [sbs_pkg::COORD_WIDTH-1:0]   hi,
	output sbs_pkg::lane_t                           lane_s2
);

	localparam int CW = sbs_pkg::COORD_WIDTH;
	localparam int DW = sbs_pkg::DIFF_W;
	localparam int NW = sbs_pkg::NUM_W;

	logic signed [DW-1:0] d_s1, a_s1, b_s1;
	logic                 swap_s1, pok_s1;

	// stage 1: differences against the start point
	always_ff @(posedge clk) begin
		d_s1    <= {e[CW-1], e} - {s[CW-1], s};
		a_s1    <= {lo[CW-1], lo} - {s[CW-1], s};
		b_s1    <= {hi[CW-1], hi} - {s[CW-1], s};
		swap_s1 <= lo > hi;
		pok_s1  <= (s >= lo) && (s <= hi);
	end

	logic                 neg;
	logic signed [DW-1:0] n0_raw, n1_raw;
	logic signed [NW-1:0] n0_ext, n1_ext;
	logic [DW:0]          d_neg;
	sbs_pkg::lane_t       lane_d;

	// stage 2: flip a backward axis so the denominator is positive, then sort
	always_comb begin
		neg    = d_s1[DW-1];
		n0_raw = (swap_s1 ^ neg) ? b_s1 : a_s1;
		n1_raw = (swap_s1 ^ neg) ? a_s1 : b_s1;
		n0_ext = {{(NW-DW){n0_raw[DW-1]}}, n0_raw};
		n1_ext = {{(NW-DW){n1_raw[DW-1]}}, n1_raw};
		d_neg  = -{d_s1[DW-1], d_s1};
		lane_d.par    = (d_s1 == '0);
		lane_d.par_ok = pok_s1;
		lane_d.n0     = neg ? -n0_ext : n0_ext;
		lane_d.n1     = neg ? -n1_ext : n1_ext;
		lane_d.dm     = neg ? d_neg[DW-1:0] : d_s1;
	end

	always_ff @(posedge clk) begin
		lane_s2 <= lane_d;
	end

endmodule

### rtl/sbs_cross_lane.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbs_cross_lane
// cross products of one axis against the other axes, bounds against [0,1]
// ---------------------------------------------------------------------------
module sbs_cross_lane (
	input  logic            clk,
	input  sbs_pkg::lane_t  own_s2,
	input  sbs_pkg::lane_t  next_s2,
	input  sbs_pkg::lane_t  after_s2,
	output sbs_pkg::prod_t  prod_s3
);

	localparam int NW = sbs_pkg::NUM_W;
	localparam int DW = sbs_pkg::DIFF_W;
	localparam int PW = sbs_pkg::PROD_W;

	logic signed [NW-1:0] d_own, d_next, d_after, n0, n1;
	sbs_pkg::prod_t       prod_d;

	always_comb begin
		d_own   = $signed({{(NW-DW){1'b0}}, own_s2.dm});
		d_next  = $signed({{(NW-DW){1'b0}}, next_s2.dm});
		d_after = $signed({{(NW-DW){1'b0}}, after_s2.dm});
		n0      = own_s2.n0;
		n1      = own_s2.n1;
		prod_d.par = own_s2.par;
		// moving axis: exit not before 0 and entry not after 1
		prod_d.ok  = own_s2.par ? own_s2.par_ok : (!n1[NW-1] && (n0 <= d_own));
		prod_d.p0_a = PW'(n0) * PW'(d_next);
		prod_d.p0_b = PW'(n0) * PW'(d_after);
		prod_d.p1_a = PW'(n1) * PW'(d_next);
		prod_d.p1_b = PW'(n1) * PW'(d_after);
	end

	always_ff @(posedge clk) begin
		prod_s3 <= prod_d;
	end

endmodule

### rtl/sbs_merge.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbs_merge
// combines the lanes: every entry must lie at or before every exit
// ---------------------------------------------------------------------------
module sbs_merge (
	input  logic            clk,
	input  sbs_pkg::prod_t  prod_s3 [sbs_pkg::NUM_AXES],
	output logic            hit_s4
);

	logic [sbs_pkg::NUM_AXES-1:0] fwd_ok, back_ok, skip_fwd, skip_back;
	logic                         hit_d;

	// entry of axis i against exit of axis i+1 and of axis i+2;
	// a parallel axis puts no bound on the segment parameter
	always_comb begin
		for (int i = 0; i < sbs_pkg::NUM_AXES; i++) begin
			skip_fwd[i]  = prod_s3[i].par || prod_s3[(i + 1) % sbs_pkg::NUM_AXES].par;
			skip_back[i] = prod_s3[i].par || prod_s3[(i + 2) % sbs_pkg::NUM_AXES].par;
			fwd_ok[i]  = skip_fwd[i] || ($signed(prod_s3[i].p0_a) <=
				$signed(prod_s3[(i + 1) % sbs_pkg::NUM_AXES].p1_b));
			back_ok[i] = skip_back[i] || ($signed(prod_s3[i].p0_b) <=
				$signed(prod_s3[(i + 2) % sbs_pkg::NUM_AXES].p1_a));
		end
		hit_d = &fwd_ok && &back_ok && prod_s3[0].ok && prod_s3[1].ok && prod_s3[2].ok;
	end

	always_ff @(posedge clk) begin
		hit_s4 <= hit_d;
	end

endmodule

### rtl/segment_box_slab_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// segment_box_slab_test
// exact slab test of a 3d segment against an axis-aligned box
// ---------------------------------------------------------------------------
//
//  channel   direction  handshake           payload
//  -------   ---------  ------------------  --------------------------------
//  command   in         start & !busy       start_*, end_*, box_lo_*, box_hi_*
//  result    out        done (one cycle)    hit
//
//  one transaction is taken every cycle; busy stays low
//  the result appears after two lane stages, one multiply stage and
//  one merge stage, one per command, in order
//  the rate is set by the three axis lanes, each with its own multipliers
//  reset clears the valid pipeline only; commands in flight are dropped
//  the receiver cannot stall, so nothing inside ever waits
//
module segment_box_slab_test (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	output logic                                    busy,
	input  logic signed [sbs_pkg::COORD_WIDTH-1:0]  start_x,
	input  logic signed [sbs_pkg::COORD_WIDTH-1:0]  start_y,
	input  logic signed [sbs_pkg::COORD_WIDTH-1:0]  start_z,
	input  logic signed [sbs_pkg::COORD_WIDTH-1:0]  end_x,
	input  logic signed [sbs_pkg::COORD_WIDTH-1:0]  end_y,
	input  logic signed [sbs_pkg::COORD_WIDTH-1:0]  end_z,
	input  logic signed [sbs_pkg::COORD_WIDTH-1:0]  box_lo_x,
	input  logic signed [sbs_pkg::COORD_WIDTH-1:0]  box_lo_y,
	input  logic signed [sbs_pkg::COORD_WIDTH-1:0]  box_lo_z,
	input  logic signed [sbs_pkg::COORD_WIDTH-1:0]  box_hi_x,
	input  logic signed [sbs_pkg::COORD_WIDTH-1:0]  box_hi_y,
	input  logic signed [sbs_pkg::COORD_WIDTH-1:0]  box_hi_z,
	output logic                                    done,
	output logic                                    hit
);

	localparam int NA = sbs_pkg::NUM_AXES;
	localparam int CW = sbs_pkg::COORD_WIDTH;

	// per-axis views of the command
	logic signed [CW-1:0] s_ax  [NA];
	logic signed [CW-1:0] e_ax  [NA];
	logic signed [CW-1:0] lo_ax [NA];
	logic signed [CW-1:0] hi_ax [NA];

	assign s_ax  = '{start_x, start_y, start_z};
	assign e_ax  = '{end_x, end_y, end_z};
	assign lo_ax = '{box_lo_x, box_lo_y, box_lo_z};
	assign hi_ax = '{box_hi_x, box_hi_y, box_hi_z};

	sbs_pkg::lane_t lane_s2 [NA];
	sbs_pkg::prod_t prod_s3 [NA];
	logic           hit_s4;

	// transaction valid travelling alongside the data
	logic v_s1, v_s2, v_s3, v_s4;

	// axis lanes: differences, flip and sort, then cross products against
	// the denominators of the two other axes
	for (genvar g = 0; g < NA; g++) begin : g_lane
		sbs_axis_lane u_axis (
			.clk     (clk),
			.s       (s_ax[g]),
			.e       (e_ax[g]),
			.lo      (lo_ax[g]),
			.hi      (hi_ax[g]),
			.lane_s2 (lane_s2[g])
		);

		sbs_cross_lane u_cross (
			.clk      (clk),
			.own_s2   (lane_s2[g]),
			.next_s2  (lane_s2[(g + 1) % NA]),
			.after_s2 (lane_s2[(g + 2) % NA]),
			.prod_s3  (prod_s3[g])
		);
	end

	// merge: latest entry against earliest exit, parallel axes folded in
	sbs_merge u_merge (
		.clk     (clk),
		.prod_s3 (prod_s3),
		.hit_s4  (hit_s4)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// fully pipelined, so a command is never refused
	assign busy = 1'b0;
	assign done = v_s4;
	assign hit  = v_s4 & hit_s4;

endmodule

### rtl/sbs_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbs_checker
// port-level checks on command/result timing of the slab test
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sbs_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  logic done,
	input  logic hit
);

	logic accepted;
	assign accepted = start && !busy;

	// the pipeline never refuses a transaction
	`SBS_ASSERT_ALWAYS(a_never_busy, clk, arst_n, !busy)
	// every accepted transaction yields a result after the fixed latency
	`SBS_ASSERT_LATER(a_result_follows, clk, arst_n, accepted, 4, done)
	// no result without an accepted transaction before it
	`SBS_ASSERT_IMPL(a_no_spurious, clk, arst_n, done, $past(accepted, sbs_pkg::LATENCY))
	// hit is only shown alongside the strobe
	`SBS_ASSERT_IMPL(a_hit_quiet, clk, arst_n, !done, !hit)

endmodule

bind segment_box_slab_test sbs_checker u_sbs_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.hit    (hit)
);

### tb/sv/segment_box_slab_test_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// segment_box_slab_test testbench
// drives directed, then random segment/box commands in bursts, predicts each
// hit flag with exact wide-integer rational arithmetic, checks results in order
// ---------------------------------------------------------------------------
module testbench;

	localparam int CW          = sbs_pkg::COORD_WIDTH;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_CMDS = 550;

	typedef logic signed [CW-1:0]  coord_t;
	// wide enough for every difference and every cross product
	typedef logic signed [127:0]   wide_t;

	// one command: segment end points and box corners, indexed x, y, z
	typedef struct {
		coord_t seg_a[3];
		coord_t seg_b[3];
		coord_t box_lo[3];
		coord_t box_hi[3];
	} segbox_t;

	localparam coord_t C_MIN = {1'b1, {(CW-1){1'b0}}};
	localparam coord_t C_MAX = {1'b0, {(CW-1){1'b1}}};

	// -----------------------------------------------------------------------
	// scoreboard: predicted hit flags, oldest first
	// -----------------------------------------------------------------------
	class slab_scoreboard;
		bit expected_hits[$];
		int errors;
		int commands;
		int results;
		int hits;
		int misses;

		function new();
			errors   = 0;
			commands = 0;
			results  = 0;
			hits     = 0;
			misses   = 0;
		endfunction

		// exact slab test; the segment parameter runs over [0,1]
		function bit slab_hit(segbox_t c);
			wide_t en_n, en_d, ex_n, ex_d;
			wide_t s, lo, hi, d, n0, n1, tmp;
			bit    meets;
			en_n  = 0;
			en_d  = 1;
			ex_n  = 1;
			ex_d  = 1;
			meets = 1'b1;
			for (int ax = 0; ax < 3 && meets; ax++) begin
				s  = c.seg_a[ax];
				lo = c.box_lo[ax];
				hi = c.box_hi[ax];
				d  = wide_t'(c.seg_b[ax]) - s;
				if (d == 0) begin
					// no movement on this axis: the start must lie in the slab
					if (s < lo || s > hi)
						meets = 1'b0;
				end else begin
					n0 = lo - s;
					n1 = hi - s;
					if (d < 0) begin
						d  = -d;
						n0 = -n0;
						n1 = -n1;
					end
					// an inverted box on a moving axis just swaps the slab ends
					if (n0 > n1) begin
						tmp = n0;
						n0  = n1;
						n1  = tmp;
					end
					if (n0 * en_d > en_n * d) begin
						en_n = n0;
						en_d = d;
					end
					if (ex_n * d > n1 * ex_d) begin
						ex_n = n1;
						ex_d = d;
					end
					// ties between entry and exit are a graze and still a hit
					if (en_n * ex_d > ex_n * en_d)
						meets = 1'b0;
				end
			end
			return meets;
		endfunction

		function void note_command(segbox_t c);
			expected_hits.insert(expected_hits.size(), slab_hit(c));
			commands++;
		endfunction

		function int pending();
			return expected_hits.size();
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(logic hit_out);
			bit predicted;
			results++;
			if (expected_hits.size() == 0) begin
				report($sformatf("hit=%b with no transaction outstanding", hit_out));
			end else begin
				predicted = expected_hits.pop_front();
				if (hit_out !== predicted)
					report($sformatf("result %0d: hit=%b, predicted %b",
						results, hit_out, predicted));
				if (predicted)
					hits++;
				else
					misses++;
			end
		endtask
	endclass

	// -----------------------------------------------------------------------
	// clock, reset and block ports
	// -----------------------------------------------------------------------
	logic   clk    = 1'b0;
	logic   arst_n = 1'b0;
	logic   start  = 1'b0;
	logic   busy;
	logic   done;
	logic   hit;
	coord_t start_x  = '0, start_y  = '0, start_z  = '0;
	coord_t end_x    = '0, end_y    = '0, end_z    = '0;
	coord_t box_lo_x = '0, box_lo_y = '0, box_lo_z = '0;
	coord_t box_hi_x = '0, box_hi_y = '0, box_hi_z = '0;

	int cycle_count = 0;
	int burst_left  = 0;

	slab_scoreboard sb = new();

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	segment_box_slab_test DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.start_x  (start_x),
		.start_y  (start_y),
		.start_z  (start_z),
		.end_x    (end_x),
		.end_y    (end_y),
		.end_z    (end_z),
		.box_lo_x (box_lo_x),
		.box_lo_y (box_lo_y),
		.box_lo_z (box_lo_z),
		.box_hi_x (box_hi_x),
		.box_hi_y (box_hi_y),
		.box_hi_z (box_hi_z),
		.done     (done),
		.hit      (hit)
	);

	// -----------------------------------------------------------------------
	// monitors: sampled at the rising edge, before the block's own updates
	// -----------------------------------------------------------------------
	always @(posedge clk) begin
		segbox_t c;
		if (arst_n && start && !busy) begin
			c.seg_a  = '{start_x, start_y, start_z};
			c.seg_b  = '{end_x, end_y, end_z};
			c.box_lo = '{box_lo_x, box_lo_y, box_lo_z};
			c.box_hi = '{box_hi_x, box_hi_y, box_hi_z};
			sb.note_command(c);
		end
	end

	// results cannot be held off, so every strobe is checked as it comes
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(hit);
	end

	// watchdog against a hung or silent block
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d transactions outstanding",
				cycle_count, sb.pending());
			$display("segment_box_slab_test verification failed");
			$finish;
		end
	end

	// -----------------------------------------------------------------------
	// stimulus helpers
	// -----------------------------------------------------------------------
	function automatic segbox_t make_cmd(coord_t sx, coord_t sy, coord_t sz,
			coord_t ex, coord_t ey, coord_t ez,
			coord_t lx, coord_t ly, coord_t lz,
			coord_t hx, coord_t hy, coord_t hz);
		segbox_t c;
		c.seg_a  = '{sx, sy, sz};
		c.seg_b  = '{ex, ey, ez};
		c.box_lo = '{lx, ly, lz};
		c.box_hi = '{hx, hy, hz};
		return c;
	endfunction

	// extreme and near-extreme values, with the odd fully random one
	function automatic coord_t edge_value();
		unique case ($urandom_range(0, 6))
			0: return C_MIN;
			1: return C_MAX;
			2: return C_MIN + coord_t'(1);
			3: return C_MAX - coord_t'(1);
			4: return coord_t'(0);
			5: return coord_t'(-1);
			default: return coord_t'($urandom);
		endcase
	endfunction

	// random command; most are clustered so that hits, grazes and
	// parallel axes happen often, the rest are fully random or extreme values
	function automatic segbox_t random_cmd();
		segbox_t c;
		int      mode;
		int      spread;
		coord_t  base, tmp;
		mode   = $urandom_range(0, 9);
		spread = (mode == 9) ? (1 << $urandom_range(4, 28)) : 16;
		for (int ax = 0; ax < 3; ax++) begin
			base = coord_t'($urandom);
			unique case (mode)
				0, 1: begin
					c.seg_a[ax]  = coord_t'($urandom);
					c.seg_b[ax]  = coord_t'($urandom);
					c.box_lo[ax] = coord_t'($urandom);
					c.box_hi[ax] = coord_t'($urandom);
				end
				7, 8: begin
					c.seg_a[ax]  = edge_value();
					c.seg_b[ax]  = edge_value();
					c.box_lo[ax] = edge_value();
					c.box_hi[ax] = edge_value();
				end
				default: begin
					c.seg_a[ax]  = base + coord_t'(int'($urandom_range(0, 2 * spread)) - spread);
					c.seg_b[ax]  = base + coord_t'(int'($urandom_range(0, 2 * spread)) - spread);
					c.box_lo[ax] = base + coord_t'(int'($urandom_range(0, spread)) - spread / 2);
					c.box_hi[ax] = base + coord_t'(int'($urandom_range(0, spread)) - spread / 2);
				end
			endcase
			// keep most boxes well formed, a few stay inverted
			if (c.box_lo[ax] > c.box_hi[ax] && $urandom_range(0, 7) != 0) begin
				tmp           = c.box_lo[ax];
				c.box_lo[ax]  = c.box_hi[ax];
				c.box_hi[ax]  = tmp;
			end
			if ($urandom_range(0, 3) == 0)
				c.seg_b[ax] = c.seg_a[ax];
		end
		// now and then a segment that is a single point
		if ($urandom_range(0, 15) == 0)
			c.seg_b = c.seg_a;
		return c;
	endfunction

	// present one command and hold it until the block takes it
	task send_command(segbox_t c);
		start    <= 1'b1;
		start_x  <= c.seg_a[0];
		start_y  <= c.seg_a[1];
		start_z  <= c.seg_a[2];
		end_x    <= c.seg_b[0];
		end_y    <= c.seg_b[1];
		end_z    <= c.seg_b[2];
		box_lo_x <= c.box_lo[0];
		box_lo_y <= c.box_lo[1];
		box_lo_z <= c.box_lo[2];
		box_hi_x <= c.box_hi[0];
		box_hi_y <= c.box_hi[1];
		box_hi_z <= c.box_hi[2];
		do
			@(posedge clk);
		while (busy);
	endtask

	// bursts of random length separated by random idle gaps;
	// some bursts are long with no gaps at all
	task pace_sender();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 12);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// stop sending until every predicted result has come back
	task drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (sbs_pkg::LATENCY + 2) @(posedge clk);
	endtask

	// -----------------------------------------------------------------------
	// main sequence
	// -----------------------------------------------------------------------
	initial begin
		segbox_t directed[$];

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part; the box is [0,10] on every axis unless noted
		// point segment inside, outside and on a corner
		directed.insert(directed.size(),
			make_cmd(5, 5, 5, 5, 5, 5, 0, 0, 0, 10, 10, 10));
		directed.insert(directed.size(),
			make_cmd(11, 5, 5, 11, 5, 5, 0, 0, 0, 10, 10, 10));
		directed.insert(directed.size(),
			make_cmd(10, 10, 10, 10, 10, 10, 0, 0, 0, 10, 10, 10));
		// straight through, both directions
		directed.insert(directed.size(),
			make_cmd(-5, 5, 5, 15, 5, 5, 0, 0, 0, 10, 10, 10));
		directed.insert(directed.size(),
			make_cmd(15, 5, 5, -5, 5, 5, 0, 0, 0, 10, 10, 10));
		// ends exactly on a face, starts on a face, stops short
		directed.insert(directed.size(),
			make_cmd(-5, 5, 5, 0, 5, 5, 0, 0, 0, 10, 10, 10));
		directed.insert(directed.size(),
			make_cmd(10, 5, 5, 20, 5, 5, 0, 0, 0, 10, 10, 10));
		directed.insert(directed.size(),
			make_cmd(-5, 5, 5, -1, 5, 5, 0, 0, 0, 10, 10, 10));
		// grazes an edge (entry equals exit), then just misses it
		directed.insert(directed.size(),
			make_cmd(-10, 0, 5, 10, 20, 5, 0, 0, 0, 10, 10, 10));
		directed.insert(directed.size(),
			make_cmd(-10, 1, 5, 10, 21, 5, 0, 0, 0, 10, 10, 10));
		// inverted box on a moving axis acts as the slab [hi, lo]
		directed.insert(directed.size(),
			make_cmd(-5, 5, 5, 15, 5, 5, 10, 0, 0, 0, 10, 10));
		// inverted box on a parallel axis always misses
		directed.insert(directed.size(),
			make_cmd(-5, 5, 5, 15, 5, 5, 0, 10, 0, 10, 0, 10));
		// parallel axis on the slab bound, then just outside it
		directed.insert(directed.size(),
			make_cmd(-5, 10, 5, 15, 10, 5, 0, 0, 0, 10, 10, 10));
		directed.insert(directed.size(),
			make_cmd(-5, 11, 5, 15, 11, 5, 0, 0, 0, 10, 10, 10));
		// full-range diagonal through a full-range box
		directed.insert(directed.size(),
			make_cmd(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX,
			C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX));
		// degenerate boxes at the far corners, reached at the segment ends
		directed.insert(directed.size(),
			make_cmd(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX,
			C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX));
		directed.insert(directed.size(),
			make_cmd(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN,
			C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN));
		// extreme crossing diagonal that passes the origin at different times
		directed.insert(directed.size(),
			make_cmd(C_MAX, C_MIN, 0, C_MIN, C_MAX, 0,
			0, 0, 0, 0, 0, 0));
		// all ones everywhere
		directed.insert(directed.size(),
			make_cmd(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
		// point box at the origin: on the segment, then just off it
		directed.insert(directed.size(),
			make_cmd(-3, -3, -3, 3, 3, 3, 0, 0, 0, 0, 0, 0));
		directed.insert(directed.size(),
			make_cmd(-3, -3, -3, 3, 3, 4, 0, 0, 0, 0, 0, 0));

		foreach (directed[i])
			send_command(directed[i]);
		drain();

		// random part, with one full drain half way through
		for (int n = 0; n < RANDOM_CMDS; n++) begin
			send_command(random_cmd());
			if (n == RANDOM_CMDS / 2)
				drain();
			else
				pace_sender();
		end
		drain();

		$display("%0d transactions sent (%0d directed), %0d results checked",
			sb.commands, directed.size(), sb.results);
		$display("%0d hits and %0d misses predicted, %0d mismatches",
			sb.hits, sb.misses, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("segment_box_slab_test verification clean");
		else
			$display("segment_box_slab_test verification failed");
		$finish;
	end

endmodule
